### design/msp_pkg.sv
package msp_pkg;

    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int TURN_WIDTH_DEF  = 16;

    localparam int SAMPLE_W   = 32;
    localparam int SPEED_W    = 32;
    localparam int TURNS_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int ONE_TURN_W = 20;
    localparam int INV_RAD_W  = 31;
    localparam int FRAC_W     = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam int DEAD_BAND  = 655;
    localparam int JUMP_LIMIT = 131072;

    localparam logic [GAIN_W-1:0]     GAIN_RST     = 24'd65536;
    localparam logic [ONE_TURN_W-1:0] ONE_TURN_RST = 20'd411775;
    localparam logic [INV_RAD_W-1:0]  INV_RAD_RST  = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_GAIN  = 2'd0,
        CFG_ONE_TURN    = 2'd1,
        CFG_INV_RADIUS  = 2'd2,
        CFG_MANUAL_HOLD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic unwrap;
        logic tgt_mul;
        logic tgt_add;
        logic err_mul;
        logic err_sub;
        logic drv_mul;
        logic drv_sum;
        logic drv_out;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic drive_en;
    } t_dp_stat;

endpackage

### design/msp_req_if.sv
interface msp_req_if import msp_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] position_sample;
    logic signed [SAMPLE_W-1:0] target_distance;

    modport source (output valid, output mode, output position_sample,
                    output target_distance, input ready);
    modport sink   (input valid, input mode, input position_sample,
                    input target_distance, output ready);
endinterface

### design/msp_res_if.sv
interface msp_res_if import msp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      drive_valid;
    logic signed [SPEED_W-1:0] speed_command;
    logic                      at_target;
    logic                      is_homed;
    logic signed [TURNS_W-1:0] turns;

    modport source (output valid, output drive_valid, output speed_command,
                    output at_target, output is_homed, output turns, input ready);
    modport sink   (input valid, input drive_valid, input speed_command,
                    input at_target, input is_homed, input turns, output ready);
endinterface

### design/msp_datapath.sv
module msp_datapath import msp_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TURN_WIDTH  = TURN_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_mode,
    input  logic signed [SAMPLE_W-1:0]  i_position_sample,
    input  logic signed [SAMPLE_W-1:0]  i_target_distance,
    output logic                        o_drive_valid,
    output logic signed [SPEED_W-1:0]   o_speed_command,
    output logic                        o_at_target,
    output logic                        o_is_homed,
    output logic signed [TURNS_W-1:0]   o_turns
);

    localparam int AW  = ANGLE_WIDTH;
    localparam int TW  = TURN_WIDTH;
    localparam int XW  = (AW > SAMPLE_W) ? AW : SAMPLE_W;
    localparam int DW  = (AW + 1 > 20) ? AW + 1 : 20;
    localparam int FW  = TW + ONE_TURN_W + 1;
    localparam int EW  = ((FW > AW) ? FW : AW) + 2;
    localparam int LOW_W = 32;
    localparam int MW  = (EW > LOW_W + 1) ? EW : LOW_W + 1;
    localparam int HW  = MW - LOW_W;
    localparam int PW  = MW + GAIN_W;
    localparam int TPW = SAMPLE_W + INV_RAD_W;
    localparam int ASW = TPW - FRAC_W + 1;
    localparam int SW  = ((ASW > AW) ? ASW : AW) + 1;
    localparam int SAT_BIT = SPEED_W - 1 + FRAC_W;

    localparam logic signed [XW-1:0] X_MAX = {{(XW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [XW-1:0] X_MIN = ~X_MAX;
    localparam logic signed [SW-1:0] S_MAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = ~S_MAX;
    localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN = ~T_MAX;
    localparam logic signed [DW-1:0] JUMP_P = DW'(JUMP_LIMIT);
    localparam logic signed [DW-1:0] JUMP_N = -JUMP_P;
    localparam logic signed [DW-1:0] BAND_P = DW'(DEAD_BAND);
    localparam logic signed [DW-1:0] BAND_N = -BAND_P;
    localparam logic signed [EW-1:0] E_BAND = EW'(DEAD_BAND);
    localparam logic [SPEED_W-1:0] SPD_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic [SPEED_W-1:0] SPD_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

    logic                        r_mode;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic signed [SAMPLE_W-1:0]  r_dist;

    logic signed [GAIN_W-1:0]    r_gain;
    logic [ONE_TURN_W-1:0]       r_one_turn;
    logic [INV_RAD_W-1:0]        r_inv_rad;
    logic                        r_manual;

    logic signed [AW-1:0]        r_prev;
    logic signed [TW-1:0]        r_turn;
    logic signed [AW-1:0]        r_home;
    logic signed [AW-1:0]        r_target;
    logic                        r_homed;
    logic                        r_done;

    logic [TPW-1:0]              r_tprod;
    logic                        r_tneg;
    logic signed [FW-1:0]        r_full;
    logic [MW-1:0]               r_err_mag;
    logic                        r_err_neg;
    logic                        r_in_band;
    logic [LOW_W+GAIN_W-1:0]     r_pp_lo;
    logic [HW+GAIN_W-1:0]        r_pp_hi;
    logic                        r_neg;
    logic [PW-1:0]               r_prod;
    logic                        r_dv;
    logic signed [SPEED_W-1:0]   r_drv;

    logic                        r_o_dv;
    logic signed [SPEED_W-1:0]   r_o_spd;
    logic                        r_o_at;
    logic                        r_o_homed;
    logic signed [TURNS_W-1:0]   r_o_turns;

    logic signed [XW-1:0]        s_ext;
    logic signed [AW-1:0]        n_sample;
    logic signed [DW-1:0]        dlt;
    logic                        jump;
    logic                        homing;
    logic signed [TW-1:0]        n_turn;
    logic [SAMPLE_W-1:0]         d_mag;
    logic signed [ASW-1:0]       t_a;
    logic signed [SW-1:0]        t_sum;
    logic signed [AW-1:0]        n_target;
    logic signed [EW-1:0]        e_sum;
    logic signed [EW-1:0]        e_abs;
    logic [GAIN_W-1:0]           g_abs;
    logic                        sat;
    logic [SPEED_W-1:0]          n_mag;
    logic [SPEED_W-1:0]          n_drv;

    // sample clamp and unwrap
    always_comb begin
        s_ext = XW'(r_sample);
        if (s_ext > X_MAX) begin
            n_sample = AW'(X_MAX);
        end else if (s_ext < X_MIN) begin
            n_sample = AW'(X_MIN);
        end else begin
            n_sample = AW'(s_ext);
        end
        dlt    = DW'(n_sample) - DW'(r_prev);
        jump   = (r_prev != '0) && ((dlt > JUMP_P) || (dlt < JUMP_N));
        homing = !r_homed && (dlt <= BAND_P) && (dlt >= BAND_N) && (n_sample != '0);
        n_turn = r_turn;
        if (jump) begin
            if (dlt < 0) begin
                if (r_turn != T_MAX) n_turn = r_turn + TW'(1);
            end else begin
                if (r_turn != T_MIN) n_turn = r_turn - TW'(1);
            end
        end
    end

    // target conversion
    always_comb begin
        d_mag = r_dist[SAMPLE_W-1] ? SAMPLE_W'(-r_dist) : SAMPLE_W'(r_dist);
        t_a   = signed'({1'b0, r_tprod[TPW-1:FRAC_W]});
        if (r_tneg) t_a = -t_a;
        t_sum = SW'(t_a) + SW'(r_home);
        if (t_sum > S_MAX) begin
            n_target = AW'(S_MAX);
        end else if (t_sum < S_MIN) begin
            n_target = AW'(S_MIN);
        end else begin
            n_target = AW'(t_sum);
        end
    end

    // error and drive
    always_comb begin
        e_sum = EW'(r_target) - (EW'(r_full) + EW'(r_prev));
        e_abs = (e_sum < 0) ? -e_sum : e_sum;
        g_abs = r_gain[GAIN_W-1] ? GAIN_W'(-r_gain) : GAIN_W'(r_gain);
        sat   = |r_prod[PW-1:SAT_BIT];
        n_mag = sat ? SPD_MIN : {1'b0, r_prod[SAT_BIT-1:FRAC_W]};
        if (r_in_band) begin
            n_drv = '0;
        end else if (r_neg) begin
            n_drv = -n_mag;
        end else begin
            n_drv = sat ? SPD_MAX : n_mag;
        end
    end

    assign o_stat.drive_en = r_homed && (r_home != '0) && !r_manual;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= signed'(GAIN_RST);
            r_one_turn <= ONE_TURN_RST;
            r_inv_rad  <= INV_RAD_RST;
            r_manual   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED_GAIN:  r_gain     <= signed'(i_cfg_data[GAIN_W-1:0]);
                CFG_ONE_TURN:    r_one_turn <= i_cfg_data[ONE_TURN_W-1:0];
                CFG_INV_RADIUS:  r_inv_rad  <= i_cfg_data[INV_RAD_W-1:0];
                CFG_MANUAL_HOLD: r_manual   <= i_cfg_data[0];
                default:         r_manual   <= r_manual;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_turn   <= '0;
            r_home   <= '0;
            r_target <= '0;
            r_homed  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_cmd.unwrap) begin
                r_prev <= n_sample;
                if (homing) begin
                    r_home   <= n_sample;
                    r_target <= n_sample;
                    r_turn   <= '0;
                    r_done   <= 1'b1;
                    r_homed  <= 1'b1;
                end else begin
                    r_turn <= n_turn;
                end
            end
            if (i_cmd.tgt_add) begin
                r_target <= n_target;
                r_done   <= 1'b0;
            end
            if (i_cmd.drv_out) begin
                r_done <= r_in_band;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_sample <= i_position_sample;
            r_dist   <= i_target_distance;
        end
        if (i_cmd.unwrap) begin
            r_dv  <= 1'b0;
            r_drv <= '0;
        end
        if (i_cmd.tgt_mul) begin
            r_tprod <= d_mag * r_inv_rad;
            r_tneg  <= r_dist[SAMPLE_W-1] && r_mode;
        end
        if (i_cmd.err_mul) begin
            r_full <= r_turn * signed'({1'b0, r_one_turn});
        end
        if (i_cmd.err_sub) begin
            r_err_mag <= MW'(unsigned'(e_abs));
            r_err_neg <= e_sum < 0;
            r_in_band <= e_abs <= E_BAND;
        end
        if (i_cmd.drv_mul) begin
            r_pp_lo <= r_err_mag[LOW_W-1:0] * g_abs;
            r_pp_hi <= r_err_mag[MW-1:LOW_W] * g_abs;
            r_neg   <= r_err_neg ^ r_gain[GAIN_W-1];
        end
        if (i_cmd.drv_sum) begin
            r_prod <= PW'({r_pp_hi, {LOW_W{1'b0}}}) + PW'(r_pp_lo);
        end
        if (i_cmd.drv_out) begin
            r_dv  <= 1'b1;
            r_drv <= signed'(n_drv);
        end
        if (i_cmd.load_out) begin
            r_o_dv    <= r_dv;
            r_o_spd   <= r_drv;
            r_o_at    <= r_done;
            r_o_homed <= r_homed;
            r_o_turns <= TURNS_W'(r_turn);
        end
    end

    assign o_drive_valid   = r_o_dv;
    assign o_speed_command = r_o_spd;
    assign o_at_target     = r_o_at;
    assign o_is_homed      = r_o_homed;
    assign o_turns         = r_o_turns;

endmodule

### design/msp_ctrl.sv
module msp_ctrl import msp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_mode,
    output logic     o_req_ready,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_UNWRAP  = 10'b00_0000_0010,
        ST_TGT_MUL = 10'b00_0000_0100,
        ST_TGT_ADD = 10'b00_0000_1000,
        ST_ERR_MUL = 10'b00_0001_0000,
        ST_ERR_SUB = 10'b00_0010_0000,
        ST_DRV_MUL = 10'b00_0100_0000,
        ST_DRV_SUM = 10'b00_1000_0000,
        ST_DRV_OUT = 10'b01_0000_0000,
        ST_RESULT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   load;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign load        = (r_state == ST_RESULT) && (!r_res_valid || i_res_ready);

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == ST_IDLE) && i_req_valid;
        o_cmd.unwrap   = (r_state == ST_UNWRAP);
        o_cmd.tgt_mul  = (r_state == ST_TGT_MUL);
        o_cmd.tgt_add  = (r_state == ST_TGT_ADD);
        o_cmd.err_mul  = (r_state == ST_ERR_MUL);
        o_cmd.err_sub  = (r_state == ST_ERR_SUB);
        o_cmd.drv_mul  = (r_state == ST_DRV_MUL);
        o_cmd.drv_sum  = (r_state == ST_DRV_SUM);
        o_cmd.drv_out  = (r_state == ST_DRV_OUT);
        o_cmd.load_out = load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = i_req_mode ? ST_TGT_MUL : ST_UNWRAP;
            end
            ST_UNWRAP:  n_state = i_stat.drive_en ? ST_ERR_MUL : ST_RESULT;
            ST_TGT_MUL: n_state = ST_TGT_ADD;
            ST_TGT_ADD: n_state = ST_IDLE;
            ST_ERR_MUL: n_state = ST_ERR_SUB;
            ST_ERR_SUB: n_state = ST_DRV_MUL;
            ST_DRV_MUL: n_state = ST_DRV_SUM;
            ST_DRV_SUM: n_state = ST_DRV_OUT;
            ST_DRV_OUT: n_state = ST_RESULT;
            ST_RESULT: begin
                if (load) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (load) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

### design/multiturn_position_servo.sv
// channel   dir  handshake          payload
// i_req     in   valid/ready        mode, position_sample, target_distance
// o_res     out  valid/ready        drive_valid, speed_command, at_target, is_homed, turns
// i_cfg     in   write enable only  i_cfg_idx, i_cfg_data
//
// Target request: accept, multiply, add; no result.
// Sample request: accept, unwrap, result; with drive also two multiplies, sum, saturate;
// the work is serialized through one controller, one request at a time.
// Result sits in an output register; the next request is taken while it waits.
// A full output register stalls the controller only when the next result is due.
// Reset is synchronous and active low; it restores the register defaults.
module multiturn_position_servo import msp_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TURN_WIDTH  = TURN_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    msp_req_if.sink               i_req,
    msp_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    msp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    msp_datapath #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TURN_WIDTH  (TURN_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_req.mode),
        .i_position_sample (i_req.position_sample),
        .i_target_distance (i_req.target_distance),
        .o_drive_valid     (o_res.drive_valid),
        .o_speed_command   (o_res.speed_command),
        .o_at_target       (o_res.at_target),
        .o_is_homed        (o_res.is_homed),
        .o_turns           (o_res.turns)
    );

endmodule

### design/msp_checker.sv
module msp_checker import msp_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic                      i_drive_valid,
    input logic signed [SPEED_W-1:0] i_speed_command,
    input logic                      i_at_target,
    input logic                      i_is_homed,
    input logic signed [TURNS_W-1:0] i_turns
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_speed_command)
            && $stable(i_drive_valid) && $stable(i_turns))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_drive_homed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_drive_valid |-> i_is_homed)
        else $error("drive before homing");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_drive_valid |-> i_speed_command == '0)
        else $error("speed without drive");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_drive_valid && i_at_target |-> i_speed_command == '0)
        else $error("speed inside dead band");

endmodule

bind multiturn_position_servo msp_checker u_msp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_drive_valid   (o_res.drive_valid),
    .i_speed_command (o_res.speed_command),
    .i_at_target     (o_res.at_target),
    .i_is_homed      (o_res.is_homed),
    .i_turns         (o_res.turns)
);

### verif/multiturn_position_servo_test.sv
module multiturn_position_servo_test import msp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit     MODE_SAMPLE   = 1'b0;
    localparam bit     MODE_TARGET   = 1'b1;
    localparam int     CYCLE_LIMIT   = 3_000_000;
    localparam int     SETTLE_CYCLES = 16;
    localparam longint DRIVE_SAT     = 64'sd2147483648;
    localparam longint PROD_CAP      = 64'sd140737488355328;
    localparam int     SWEEP_STEP    = 100_000_000;
    localparam int     TURN_SWEEP    = 120;
    localparam logic signed [SAMPLE_W-1:0] ANGLE_TOP    = 32'sh7fffffff;
    localparam logic signed [SAMPLE_W-1:0] ANGLE_BOTTOM = 32'sh80000000;

    typedef struct packed {
        logic                      drive_valid;
        logic signed [SPEED_W-1:0] speed_command;
        logic                      at_target;
        logic                      is_homed;
        logic signed [TURNS_W-1:0] turns;
    } servo_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    msp_req_if req_if ();
    msp_res_if res_if ();

    multiturn_position_servo dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // servo state mirror
    logic signed [GAIN_W-1:0]   cfg_gain   = GAIN_RST;
    logic [ONE_TURN_W-1:0]      cfg_turn   = ONE_TURN_RST;
    logic [INV_RAD_W-1:0]       cfg_inv    = INV_RAD_RST;
    logic                       cfg_hold   = 1'b0;
    logic signed [SAMPLE_W-1:0] last_angle    = '0;
    logic signed [SAMPLE_W-1:0] earlier_angle = '0;
    logic signed [TURNS_W-1:0]  turn_cnt      = '0;
    logic signed [SAMPLE_W-1:0] home_pos      = '0;
    logic signed [SAMPLE_W-1:0] target_pos    = '0;
    logic                       homed_f       = 1'b0;
    logic                       done_f        = 1'b0;

    servo_result_t servo_results_due [$];
    int            mismatches      = 0;
    bit            sender_idles    = 1'b1;
    bit            receiver_stalls = 1'b1;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [SPEED_W-1:0] scaled_drive(input longint err,
                                                               input longint gain);
        longint ma;
        longint mg;
        longint p;
        bit     neg;
        ma  = mag(err);
        mg  = mag(gain);
        neg = (err < 0) != (gain < 0);
        if (ma == 0 || mg == 0) return '0;
        if (ma > PROD_CAP / mg) begin
            p = DRIVE_SAT;
        end else begin
            p = (ma * mg) >>> FRAC_W;
            if (p > DRIVE_SAT) p = DRIVE_SAT;
        end
        if (neg) return SPEED_W'(-p);
        if (p > DRIVE_SAT - 1) p = DRIVE_SAT - 1;
        return SPEED_W'(p);
    endfunction

    function automatic void advance_servo(input bit mode,
                                          input logic signed [SAMPLE_W-1:0] sample,
                                          input logic signed [SAMPLE_W-1:0] tgt_dist);
        longint        d;
        longint        ang;
        longint        s;
        longint        err;
        servo_result_t r;
        if (mode == MODE_TARGET) begin
            d   = longint'(tgt_dist);
            ang = (mag(d) * longint'(cfg_inv)) >>> FRAC_W;
            if (d < 0) ang = -ang;
            target_pos = SAMPLE_W'(clamp_signed(ang + longint'(home_pos), SAMPLE_W));
            done_f     = 1'b0;
            return;
        end
        s = longint'(sample);
        if (last_angle != 0 && mag(s - longint'(last_angle)) > JUMP_LIMIT) begin
            if (longint'(last_angle) - s > 0)
                turn_cnt = TURNS_W'(clamp_signed(longint'(turn_cnt) + 1, TURNS_W));
            else
                turn_cnt = TURNS_W'(clamp_signed(longint'(turn_cnt) - 1, TURNS_W));
        end
        earlier_angle = last_angle;
        last_angle    = sample;
        r = '0;
        if (homed_f) begin
            if (home_pos != 0 && !cfg_hold) begin
                err = longint'(target_pos)
                    - (longint'(turn_cnt) * longint'(cfg_turn) + longint'(last_angle));
                r.drive_valid = 1'b1;
                if (mag(err) <= DEAD_BAND) begin
                    done_f = 1'b1;
                end else begin
                    done_f          = 1'b0;
                    r.speed_command = scaled_drive(err, longint'(cfg_gain));
                end
            end
        end else if (mag(longint'(earlier_angle) - longint'(last_angle)) <= DEAD_BAND
                     && last_angle != 0) begin
            home_pos   = last_angle;
            target_pos = last_angle;
            turn_cnt   = '0;
            done_f     = 1'b1;
            homed_f    = 1'b1;
        end
        r.at_target = done_f;
        r.is_homed  = homed_f;
        r.turns     = turn_cnt;
        servo_results_due.push_back(r);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : cycle_watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : result_backpressure
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    initial begin : result_checker
        servo_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (servo_results_due.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = servo_results_due.pop_front();
                    if (res_if.drive_valid !== want.drive_valid) begin
                        $error("drive_valid: expected %0d, got %0d",
                               want.drive_valid, res_if.drive_valid);
                        mismatches++;
                    end
                    if (res_if.speed_command !== want.speed_command) begin
                        $error("speed_command: expected %0d, got %0d",
                               want.speed_command, res_if.speed_command);
                        mismatches++;
                    end
                    if (res_if.at_target !== want.at_target) begin
                        $error("at_target: expected %0d, got %0d",
                               want.at_target, res_if.at_target);
                        mismatches++;
                    end
                    if (res_if.is_homed !== want.is_homed) begin
                        $error("is_homed: expected %0d, got %0d",
                               want.is_homed, res_if.is_homed);
                        mismatches++;
                    end
                    if (res_if.turns !== want.turns) begin
                        $error("turns: expected %0d, got %0d", want.turns, res_if.turns);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic send_request(input bit mode, input logic signed [SAMPLE_W-1:0] sample,
                                input logic signed [SAMPLE_W-1:0] tgt_dist);
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.mode            <= mode;
        req_if.position_sample <= sample;
        req_if.target_distance <= tgt_dist;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        advance_servo(mode, sample, tgt_dist);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
        send_request(MODE_SAMPLE, sample, SAMPLE_W'($urandom));
    endtask

    task automatic send_target(input logic signed [SAMPLE_W-1:0] tgt_dist);
        send_request(MODE_TARGET, SAMPLE_W'($urandom), tgt_dist);
    endtask

    // stop requesting, let every result drain, then let a trailing target request finish
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (servo_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic signed [GAIN_W-1:0] gain,
                               input logic [ONE_TURN_W-1:0] one_turn,
                               input logic [INV_RAD_W-1:0] inv_radius, input logic hold);
        t_cfg_idx              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_SPEED_GAIN, CFG_ONE_TURN, CFG_INV_RADIUS, CFG_MANUAL_HOLD};
        vals = '{CFG_DATA_W'(unsigned'(gain)), CFG_DATA_W'(one_turn),
                 CFG_DATA_W'(inv_radius), CFG_DATA_W'(hold)};
        foreach (regs[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_gain = gain;
        cfg_turn = one_turn;
        cfg_inv  = inv_radius;
        cfg_hold = hold;
        @(posedge i_clk);
    endtask

    // target before homing, turn counting before homing, zero samples, homing at the band edge
    task automatic test_homing_capture();
        send_target(ANGLE_TOP);
        send_sample(ANGLE_TOP);
        send_sample(ANGLE_BOTTOM);
        send_sample(ANGLE_TOP);
        send_sample(32'sd0);
        send_sample(32'sd0);
        send_sample(32'sd300000);
        send_sample(32'sd300656);
        send_sample(32'sd301311);
        drain_results();
    endtask

    task automatic test_dead_band_and_drive();
        send_sample(home_pos);
        send_sample(home_pos + 32'sd655);
        send_sample(home_pos - 32'sd656);
        send_target(32'sd65536);
        send_sample(home_pos);
        send_target(-32'sd655360);
        send_sample(32'sh40000000);
        send_target(ANGLE_TOP);
        send_target(ANGLE_BOTTOM);
        send_sample(ANGLE_BOTTOM);
        drain_results();
    endtask

    task automatic test_manual_hold();
        load_config(GAIN_RST, ONE_TURN_RST, INV_RAD_RST, 1'b1);
        send_sample(home_pos);
        send_target(32'sd1000000);
        send_sample(home_pos);
        drain_results();
    endtask

    task automatic test_gain_extremes();
        load_config(24'sh7fffff, 20'hfffff, 31'h7fffffff, 1'b0);
        send_target(32'sd1);
        send_target(-32'sd1);
        send_sample(32'sh12345678);
        send_sample(ANGLE_BOTTOM + 32'sd100000);
        drain_results();
        load_config(24'sh800000, '0, '0, 1'b0);
        send_target(SAMPLE_W'($urandom));
        send_sample(home_pos - 32'sh40000000);
        send_sample(home_pos + 32'sd10000);
        send_sample(home_pos);
        drain_results();
        load_config('0, ONE_TURN_RST, INV_RAD_RST, 1'b0);
        send_sample(home_pos + 32'sd50000);
        drain_results();
    endtask

    task automatic run_random_phase(input int count);
        int     kind;
        longint v;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                if ($urandom_range(0, 1) == 0)
                    send_target(SAMPLE_W'(int'($urandom_range(0, 2097152)) - 1048576));
                else
                    send_target(SAMPLE_W'($urandom));
            end else if (kind < 8) begin
                if (kind < 4) begin
                    v = longint'(last_angle) + int'($urandom_range(0, 1400)) - 700;
                end else if (kind < 7) begin
                    v = longint'(target_pos) - longint'(turn_cnt) * longint'(cfg_turn)
                      + int'($urandom_range(0, 1600)) - 800;
                end else begin
                    v = int'($urandom_range(131073, 400000));
                    if ($urandom_range(0, 1) == 0) v = -v;
                    v = v + longint'(last_angle);
                end
                send_sample(SAMPLE_W'(clamp_signed(v, SAMPLE_W)));
            end else begin
                send_sample(SAMPLE_W'($urandom));
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        load_config(GAIN_RST, ONE_TURN_RST, INV_RAD_RST, 1'b0);
        run_random_phase(200);
        load_config(GAIN_W'($urandom), ONE_TURN_W'($urandom),
                    INV_RAD_W'($urandom_range(0, 262144)), 1'b0);
        run_random_phase(200);
        load_config(24'sh7fffff, '0, 31'h7fffffff, 1'b0);
        run_random_phase(200);
        load_config(24'sh800000, 20'hfffff, '0, 1'($urandom));
        run_random_phase(200);
        load_config(GAIN_W'($urandom), ONE_TURN_W'($urandom), INV_RAD_W'($urandom),
                    1'($urandom));
        run_random_phase(200);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        load_config(GAIN_W'($urandom), ONE_TURN_W'($urandom),
                    INV_RAD_W'($urandom_range(0, 131072)), 1'b0);
        run_random_phase(200);
    endtask

    // jumps from a zero previous sample do not count, so sawtooth sweeps keep counting one way
    task automatic test_turn_sweeps();
        logic signed [SAMPLE_W-1:0] ang;
        load_config(GAIN_RST, ONE_TURN_RST, INV_RAD_RST, 1'b1);
        ang = last_angle;
        repeat (TURN_SWEEP) begin
            if (ang == 0) ang = ANGLE_TOP;
            else if (ang > SWEEP_STEP) ang = ang - SWEEP_STEP;
            else ang = '0;
            send_sample(ang);
        end
        repeat (TURN_SWEEP) begin
            if (ang == 0) ang = ANGLE_BOTTOM;
            else if (ang < -SWEEP_STEP) ang = ang + SWEEP_STEP;
            else ang = '0;
            send_sample(ang);
        end
        drain_results();
        load_config(24'sh7fffff, 20'hfffff, INV_RAD_RST, 1'b0);
        send_sample(ang + 32'sd1000);
        send_target(ANGLE_TOP);
        send_sample(ang);
        drain_results();
    endtask

    initial begin : test_sequence
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_SPEED_GAIN;
        i_cfg_data             <= '0;
        req_if.valid           <= 1'b0;
        req_if.mode            <= MODE_SAMPLE;
        req_if.position_sample <= '0;
        req_if.target_distance <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_homing_capture();
        test_dead_band_and_drive();
        test_manual_hold();
        test_gain_extremes();
        test_random_traffic();
        test_turn_sweeps();

        drain_results();
        if (mismatches == 0 && servo_results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
